// ----- rtl/stfc_pkg.sv -----
// Shared constants, types and codes of the spike train filter convolution block.
package stfc_pkg;

  // Table geometry
  localparam int unsigned MAX_TAPS    = 64;
  localparam int unsigned MAX_COLUMNS = 4;
  localparam int unsigned TAP_W       = $clog2(MAX_TAPS);
  localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
  localparam int unsigned TBL_DEPTH   = MAX_TAPS * MAX_COLUMNS;
  localparam int unsigned TBL_AW      = TAP_W + COL_W;

  // Field and register widths
  localparam int unsigned TAP_CNT_W = 7;
  localparam int unsigned COL_CNT_W = 3;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned CUR_W     = 34;
  localparam int unsigned PROD_W    = COUNT_W + 1 + COEF_W;

  // Register reset values
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST    = TAP_CNT_W'(64);
  localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_RST = COL_CNT_W'(1);

  // Configuration port
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned REG_SEL_BIT = 2;

  typedef enum logic {
    REG_TAP_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_idx_e;

  // Queues between the stages
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_BIN  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic [COUNT_W-1:0]         spike_count;
    logic [TAP_W-1:0]           tap;
    logic [COL_W-1:0]           column;
    logic signed [COEF_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]          column;
    logic signed [CUR_W-1:0]   current;
    logic                      last;
  } res_t;

  // Effective (saturated) configuration seen by the datapath
  typedef struct packed {
    logic [TAP_CNT_W-1:0] taps;
    logic [COL_CNT_W-1:0] cols;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_RUN,
    ST_DRAIN
  } back_state_e;

endpackage

// ----- rtl/stfc_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module stfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stfc_front.sv -----
// Front end: accept input items, classify them and queue them for the back end.
module stfc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic                                mode_i,
  input  logic [stfc_pkg::COUNT_W-1:0]        spike_count_i,
  input  logic [stfc_pkg::TAP_W-1:0]          coef_tap_i,
  input  logic [stfc_pkg::COL_W-1:0]          coef_column_i,
  input  logic signed [stfc_pkg::COEF_W-1:0]  coef_value_i,
  output logic                                cmd_valid_o,
  output stfc_pkg::cmd_t                      cmd_o,
  input  logic                                cmd_pop_i
);
  import stfc_pkg::*;

  cmd_t               mem_q [QUEUE_DEPTH];
  cmd_t               cmd_new;
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               accept;

  // Classify the incoming item
  always_comb begin
    cmd_new.kind        = mode_i ? CMD_BIN : CMD_LOAD;
    cmd_new.spike_count = spike_count_i;
    cmd_new.tap         = coef_tap_i;
    cmd_new.column      = coef_column_i;
    cmd_new.value       = coef_value_i;
  end

  assign full_o      = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign accept      = push_i && !full_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (accept) begin
      wr_d = (wr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
    end
    case ({accept, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + Q_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - Q_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_q] <= cmd_new;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o)
    else $error("command popped from an empty queue");

endmodule

// ----- rtl/stfc_outq.sv -----
// Result queue: hold finished results until the consumer pops them.
module stfc_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stfc_pkg::res_t  res_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output stfc_pkg::res_t  res_o
);
  import stfc_pkg::*;

  res_t               mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + Q_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - Q_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= res_i;
    end
  end

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> !empty_o)
    else $error("pushed result not visible at the queue head");

endmodule

// ----- rtl/stfc_back.sv -----
// Back end: coefficient table, spike history and the shared multiply-accumulate sequencer.
module stfc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stfc_pkg::cfg_t  cfg_i,
  input  logic            cmd_valid_i,
  input  stfc_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output stfc_pkg::res_t  res_o
);
  import stfc_pkg::*;

  back_state_e              state_q, state_d;
  logic [TAP_W-1:0]         k_q, k_d;
  logic [COL_W-1:0]         col_q, col_d;
  logic [COUNT_W-1:0]       hist_q [MAX_TAPS];
  logic [COUNT_W-1:0]       hist_d [MAX_TAPS];
  logic                     hist_shift, issue, acc_clr, col_last;
  logic                     s1_vld_q, s1_use_q, s1_use_d, s2_vld_q;
  logic [COUNT_W-1:0]       s1_cnt_q;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [CUR_W-1:0]  acc_q, acc_d;
  logic                     ram_we;
  logic [COEF_W-1:0]        ram_rdata;

  stfc_ram #(
    .Width (COEF_W),
    .Depth (TBL_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({cmd_i.tap, cmd_i.column}),
    .wdata_i (cmd_i.value),
    .raddr_i ({k_q, col_q}),
    .rdata_o (ram_rdata)
  );

  assign col_last = ((COL_CNT_W'(col_q) + COL_CNT_W'(1)) == cfg_i.cols);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    col_d      = col_q;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    hist_shift = 1'b0;
    issue      = 1'b0;
    acc_clr    = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == CMD_LOAD) begin
            ram_we = 1'b1;
          end else begin
            hist_shift = 1'b1;
            col_d      = '0;
            if (cfg_i.cols != '0) begin
              state_d = ST_WAIT;
            end
          end
        end
      end
      ST_WAIT: begin
        if (!res_full_i) begin
          acc_clr = 1'b1;
          k_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        k_d   = k_q + TAP_W'(1);
        if (k_q == TAP_W'(MAX_TAPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          res_push_o = 1'b1;
          if (col_last) begin
            state_d = ST_IDLE;
          end else begin
            col_d   = col_q + COL_W'(1);
            state_d = ST_WAIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // History: shift in a new bin, or rotate one slot per issued tap
  always_comb begin
    hist_d = hist_q;
    if (hist_shift) begin
      for (int unsigned i = 1; i < MAX_TAPS; i++) begin
        hist_d[i] = hist_q[i-1];
      end
      hist_d[0] = cmd_i.spike_count;
    end else if (issue) begin
      for (int unsigned i = 0; i < MAX_TAPS - 1; i++) begin
        hist_d[i] = hist_q[i+1];
      end
      hist_d[MAX_TAPS-1] = hist_q[0];
    end
  end

  // Multiply-accumulate datapath
  assign s1_use_d  = issue && (TAP_CNT_W'(k_q) < cfg_i.taps);
  assign prod_full = $signed({1'b0, s1_cnt_q}) * $signed(ram_rdata);
  assign prod_d    = s1_use_q ? prod_full : '0;

  always_comb begin
    if (acc_clr) begin
      acc_d = '0;
    end else if (s2_vld_q) begin
      acc_d = acc_q + CUR_W'(prod_q);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      k_q      <= '0;
      col_q    <= '0;
      s1_vld_q <= 1'b0;
      s1_use_q <= 1'b0;
      s2_vld_q <= 1'b0;
      for (int unsigned i = 0; i < MAX_TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      col_q    <= col_d;
      s1_vld_q <= issue;
      s1_use_q <= s1_use_d;
      s2_vld_q <= s1_vld_q;
      hist_q   <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cnt_q <= hist_q[0];
    prod_q   <= prod_d;
    acc_q    <= acc_d;
  end

  always_comb begin
    res_o.column  = col_q;
    res_o.current = acc_q;
    res_o.last    = col_last;
  end

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && k_q == TAP_W'(MAX_TAPS - 1)) |=>
      (state_q == ST_DRAIN && s1_vld_q))
    else $error("tap sweep did not end in drain");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_vld_q && !s2_vld_q))
    else $error("multiply-accumulate busy while sequencer idle");

endmodule

// ----- rtl/spike_train_filter_convolution.sv -----
// Top level of the spike train filter convolution block: config registers and stage wiring.
//
// Convolves a stream of spike counts with up to four post-spike filters of up to 64 taps,
// coefficients in signed Q4.20. Push an item with mode 0 to load one coefficient at
// (coef_tap, coef_column); push an item with mode 1 to present one time bin. Every bin
// yields column_count results, column 0 first, each the exact 34-bit sum over taps k of
// count(t-k) * h[k][column], with last set on the final column; a load yields nothing.
// Coefficients must be written before any bin reads them (tap 0 up to tap_count-1 of
// every column in use). The back end walks all 64 history slots through one shared
// multiply-accumulate unit for each column, so a bin occupies it once per column in use,
// while a load only writes the table. A two-entry command queue in front and a two-entry
// result queue behind let the input and output sides stall on their own. tap_count (byte
// address 0) and column_count (byte address 4) must be written over the APB port only
// while the block is idle, which the block itself does not enforce; values above 64 taps
// or 4 columns saturate, zero columns make bins update the history only.
module spike_train_filter_convolution (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input item queue
  input  logic                                push,
  output logic                                full,
  input  logic                                mode_i,
  input  logic [stfc_pkg::COUNT_W-1:0]        spike_count_i,
  input  logic [stfc_pkg::TAP_W-1:0]          coef_tap_i,
  input  logic [stfc_pkg::COL_W-1:0]          coef_column_i,
  input  logic signed [stfc_pkg::COEF_W-1:0]  coef_value_i,
  // Result queue
  output logic                                empty,
  input  logic                                pop,
  output logic [stfc_pkg::COL_W-1:0]          column_o,
  output logic signed [stfc_pkg::CUR_W-1:0]   current_o,
  output logic                                last_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stfc_pkg::PADDR_W-1:0]        paddr,
  input  logic [stfc_pkg::PDATA_W-1:0]        pwdata,
  output logic [stfc_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import stfc_pkg::*;

  logic [TAP_CNT_W-1:0] tap_count_q, tap_count_d;
  logic [COL_CNT_W-1:0] column_count_q, column_count_d;
  reg_idx_e             reg_sel;
  logic                 cfg_wr;
  cfg_t                 cfg_eff;
  logic                 cmd_valid, cmd_pop;
  cmd_t                 cmd;
  logic                 res_push, res_full;
  res_t                 res_new, res_head;

  // Register decode: one 32-bit register per word, the transfer completes in the
  // access phase with no wait states.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[REG_SEL_BIT]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    tap_count_d    = tap_count_q;
    column_count_d = column_count_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_TAP_COUNT:    tap_count_d    = pwdata[TAP_CNT_W-1:0];
        REG_COLUMN_COUNT: column_count_d = pwdata[COL_CNT_W-1:0];
        default: begin
          tap_count_d    = tap_count_q;
          column_count_d = column_count_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TAP_COUNT:    prdata = PDATA_W'(tap_count_q);
      REG_COLUMN_COUNT: prdata = PDATA_W'(column_count_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q    <= TAP_COUNT_RST;
      column_count_q <= COLUMN_COUNT_RST;
    end else begin
      tap_count_q    <= tap_count_d;
      column_count_q <= column_count_d;
    end
  end

  // Saturate the register values to what the tables can hold
  always_comb begin
    cfg_eff.taps = (tap_count_q > TAP_CNT_W'(MAX_TAPS)) ? TAP_CNT_W'(MAX_TAPS) : tap_count_q;
    cfg_eff.cols = (column_count_q > COL_CNT_W'(MAX_COLUMNS)) ?
                   COL_CNT_W'(MAX_COLUMNS) : column_count_q;
  end

  // Front end: accept and classify items
  stfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .mode_i        (mode_i),
    .spike_count_i (spike_count_i),
    .coef_tap_i    (coef_tap_i),
    .coef_column_i (coef_column_i),
    .coef_value_i  (coef_value_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Back end: load coefficients, advance the history, sum per column
  stfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_eff),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  // Result queue: hold finished results for the consumer
  stfc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_new),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_head)
  );

  assign column_o  = res_head.column;
  assign current_o = res_head.current;
  assign last_o    = res_head.last;

endmodule

// ----- tb/sv/spike_train_filter_convolution_tb.sv -----
// Self-checking testbench for the spike train filter convolution block.
`timescale 1ns / 1ps

module spike_train_filter_convolution_tb;
  import stfc_pkg::*;

  // Run shape
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 14;
  localparam int SETTLE_CYCLES   = 600;    // well past one four-column bin
  localparam int HOLD_CYCLES     = 3000;   // long receiver hold-off
  localparam int HOLD_PHASE      = 1;
  localparam int DRAIN_LIMIT     = 20000;

  // Register settings per phase, extremes and out-of-range values included
  localparam int PH_TAPS [NUM_PHASES] = '{1, 64, 0, 127, 17, 64, 100, 5, 33, 64};
  localparam int PH_COLS [NUM_PHASES] = '{1, 4, 2, 7, 0, 1, 3, 4, 2, 5};
  // Idle percentages per phase: sender gaps and receiver stalls
  localparam int PH_SEND [NUM_PHASES] = '{0, 0, 86, 0, 29, 0, 86, 0, 29, 0};
  localparam int PH_RECV [NUM_PHASES] = '{0, 0, 0, 86, 29, 0, 0, 86, 29, 86};

  // Clock, reset and block ports; every input starts at a known value
  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      push          = 1'b0;
  logic                      full;
  logic                      mode_i        = 1'b0;
  logic [COUNT_W-1:0]        spike_count_i = '0;
  logic [TAP_W-1:0]          coef_tap_i    = '0;
  logic [COL_W-1:0]          coef_column_i = '0;
  logic signed [COEF_W-1:0]  coef_value_i  = '0;
  logic                      empty;
  logic                      pop           = 1'b0;
  logic [COL_W-1:0]          column_o;
  logic signed [CUR_W-1:0]   current_o;
  logic                      last_o;
  logic                      psel          = 1'b0;
  logic                      penable       = 1'b0;
  logic                      pwrite        = 1'b0;
  logic [PADDR_W-1:0]        paddr         = '0;
  logic [PDATA_W-1:0]        pwdata        = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  spike_train_filter_convolution DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .spike_count_i (spike_count_i),
    .coef_tap_i    (coef_tap_i),
    .coef_column_i (coef_column_i),
    .coef_value_i  (coef_value_i),
    .empty         (empty),
    .pop           (pop),
    .column_o      (column_o),
    .current_o     (current_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Stimulus and checking state
  cmd_t pending_items [$];        // items waiting for the driver
  res_t expected_currents [$];    // predicted results, oldest first
  cmd_t offer;                    // item currently presented on the input side
  cmd_t taken_item;
  logic offer_live     = 1'b0;
  logic item_taken     = 1'b0;    // transfer seen at the last rising edge
  logic rst_done       = 1'b0;
  logic hold_request   = 1'b0;
  logic pop_hold       = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   mismatch_count = 0;

  // Predictor state: its own copy of the table, the history and the settings
  logic signed [COEF_W-1:0]  coef_mem    [MAX_TAPS][MAX_COLUMNS];
  logic [COUNT_W-1:0]        bin_history [MAX_TAPS];
  bit                        coef_written[MAX_TAPS][MAX_COLUMNS];
  int                        use_taps = 64;   // saturated tap_count
  int                        use_cols = 1;    // saturated column_count

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Apply one accepted item to the predictor: a load updates the table, a bin
  // shifts the history and yields one exact sum per column in use.
  task automatic convolve_item(input cmd_t item);
    longint acc;
    res_t   r;
    if (item.kind == CMD_LOAD) begin
      coef_mem[item.tap][item.column] = item.value;
      return;
    end
    for (int k = MAX_TAPS - 1; k > 0; k--) bin_history[k] = bin_history[k-1];
    bin_history[0] = item.spike_count;
    for (int c = 0; c < use_cols; c++) begin
      acc = 0;
      for (int k = 0; k < use_taps; k++)
        acc += longint'(bin_history[k]) * longint'(coef_mem[k][c]);
      r.column  = COL_W'(c);
      r.current = CUR_W'(acc);
      r.last    = (c + 1 == use_cols);
      expected_currents.push_back(r);
    end
  endtask

  // Driver: present pending items at the falling edge, hold each until its transfer
  always @(negedge clk_i) begin
    if (rst_done) begin
      if (offer_live && item_taken) offer_live = 1'b0;
      if (!offer_live && pending_items.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        offer      = pending_items.pop_front();
        offer_live = 1'b1;
      end
      push          <= offer_live;
      mode_i        <= offer.kind;
      spike_count_i <= offer.spike_count;
      coef_tap_i    <= offer.tap;
      coef_column_i <= offer.column;
      coef_value_i  <= offer.value;
    end
  end

  // Receiver: stall at random, or hold off entirely while the long hold runs
  always @(negedge clk_i) begin
    if (rst_done) pop <= !pop_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: sample both transfers at the rising edge, predict and compare
  always @(posedge clk_i) begin
    item_taken = push && !full;
    if (item_taken) begin
      taken_item.kind        = cmd_kind_e'(mode_i);
      taken_item.spike_count = spike_count_i;
      taken_item.tap         = coef_tap_i;
      taken_item.column      = coef_column_i;
      taken_item.value       = coef_value_i;
      convolve_item(taken_item);
    end
    if (pop && !empty) begin
      if (expected_currents.size() == 0) begin
        flag_mismatch($sformatf("unexpected result column %0d current %0d last %0b",
                                column_o, current_o, last_o));
      end else begin
        if (column_o !== expected_currents[0].column)
          flag_mismatch($sformatf("column %0d, predicted %0d",
                                  column_o, expected_currents[0].column));
        if (current_o !== expected_currents[0].current)
          flag_mismatch($sformatf("column %0d current %0d, predicted %0d",
                                  expected_currents[0].column, current_o,
                                  expected_currents[0].current));
        if (last_o !== expected_currents[0].last)
          flag_mismatch($sformatf("column %0d last %0b, predicted %0b",
                                  expected_currents[0].column, last_o,
                                  expected_currents[0].last));
        void'(expected_currents.pop_front());
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial begin
    wait (hold_request);
    pop_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    pop_hold = 1'b0;
  end

  // One APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << REG_SEL_BIT;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Block until every pending item is taken and every predicted result arrived
  task automatic wait_drained();
    while (pending_items.size() != 0 || offer_live || expected_currents.size() != 0)
      @(posedge clk_i);
  endtask

  // Reprogram both registers; a bin on zero columns may still be in flight, so settle first
  task automatic set_filter_shape(input int taps, input int cols);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_TAP_COUNT, PDATA_W'(taps));
    write_reg(REG_COLUMN_COUNT, PDATA_W'(cols));
    use_taps = (taps > MAX_TAPS) ? MAX_TAPS : taps;
    use_cols = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
  endtask

  task automatic queue_load(input int tap, input int col, input logic [COEF_W-1:0] value);
    cmd_t item;
    item.kind        = CMD_LOAD;
    item.spike_count = COUNT_W'($urandom());
    item.tap         = TAP_W'(tap);
    item.column      = COL_W'(col);
    item.value       = value;
    coef_written[tap][col] = 1'b1;
    pending_items.push_back(item);
  endtask

  task automatic queue_bin(input int count);
    cmd_t item;
    item.kind        = CMD_BIN;
    item.spike_count = COUNT_W'(count);
    item.tap         = TAP_W'($urandom());
    item.column      = COL_W'($urandom());
    item.value       = COEF_W'($urandom());
    pending_items.push_back(item);
  endtask

  // Coefficient with the field extremes showing up often
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return {1'b0, {(COEF_W-1){1'b1}}};
      1:       return {1'b1, {(COEF_W-1){1'b0}}};
      2:       return '0;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // Write every table entry the current shape reads but nobody has written yet
  task automatic queue_missing_coefs();
    for (int k = 0; k < use_taps; k++)
      for (int c = 0; c < use_cols; c++)
        if (!coef_written[k][c]) queue_load(k, c, pick_coef());
  endtask

  // Mostly bins, with coefficient rewrites mixed in anywhere in the table
  task automatic queue_random_item();
    int pick;
    pick = $urandom_range(7);
    if (pick < 2)
      queue_load($urandom_range(MAX_TAPS - 1), $urandom_range(MAX_COLUMNS - 1), pick_coef());
    else if (pick == 2)
      queue_bin($urandom_range(1) ? (1 << COUNT_W) - 1 : 0);
    else
      queue_bin($urandom_range((1 << COUNT_W) - 1));
  endtask

  initial begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      bin_history[k] = '0;
      for (int c = 0; c < MAX_COLUMNS; c++) coef_mem[k][c] = '0;
    end

    // Hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni   <= 1'b1;
    rst_done  = 1'b1;

    // Directed part: three taps on all four columns, extreme coefficients
    set_filter_shape(3, 4);
    for (int k = 0; k < 3; k++) begin
      queue_load(k, 0, {1'b0, {(COEF_W-1){1'b1}}});   // largest positive
      queue_load(k, 1, {1'b1, {(COEF_W-1){1'b0}}});   // most negative
    end
    queue_load(0, 2, COEF_W'(1));
    queue_load(1, 2, '1);
    queue_load(2, 2, '0);
    queue_load(0, 3, COEF_W'(24'h555555));
    queue_load(1, 3, COEF_W'(24'haaaaaa));
    queue_load(2, 3, COEF_W'(24'h0f0f0f));
    queue_load(MAX_TAPS - 1, MAX_COLUMNS - 1, COEF_W'(24'h7ff001));  // top tap, top column
    // Full bins build the largest sums, empty bins flush them back to zero
    repeat (3) queue_bin(15);
    repeat (3) queue_bin(0);
    queue_bin(10);
    queue_bin(5);

    // Random part: walk through the register settings and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_filter_shape(PH_TAPS[p], PH_COLS[p]);
      send_idle_pct  = PH_SEND[p];
      recv_stall_pct = PH_RECV[p];
      // Starve the output for a long stretch so the block backs up into full
      if (p == HOLD_PHASE) hold_request = 1'b1;
      queue_missing_coefs();
      for (int i = 0; i < ITEMS_PER_PHASE / 2; i++) queue_random_item();
      // Sender pause: let every outstanding result come out before resuming
      wait_drained();
      for (int i = 0; i < ITEMS_PER_PHASE / 2; i++) queue_random_item();
    end

    // Drain: stop stalling, wait for the last results, then watch for strays
    while (pending_items.size() != 0 || offer_live) @(posedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < DRAIN_LIMIT && expected_currents.size() != 0; n++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_currents.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived",
                              expected_currents.size()));

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
